>>> rtl/ast_pkg.sv
// Shared types, sizes and operation codes of the alert slot table.
`timescale 1ns / 1ps

package ast_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(SLOT_COUNT - 1);

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_LIST   = 2'd2;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] handle;
  } slot_t;

  typedef struct packed {
    logic             shift;
    logic             write;
    logic [IDX_W-1:0] write_idx;
    slot_t            write_data;
    slot_t            tail;
  } ring_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

>>> rtl/ast_cell.sv
// One slot of the rotating slot ring, holding an id and a message handle.
`timescale 1ns / 1ps

module ast_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  ast_pkg::slot_t shift_in,
  input  logic          write,
  input  ast_pkg::slot_t write_data,
  output ast_pkg::slot_t slot
);

  logic [31:0] id;
  logic [15:0] handle;

  always_ff @(posedge clk) begin
    if (rst) begin
      id <= '0;
    end else if (write) begin
      id <= write_data.id;
    end else if (shift) begin
      id <= shift_in.id;
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      handle <= write_data.handle;
    end else if (shift) begin
      handle <= shift_in.handle;
    end
  end

  assign slot = '{id: id, handle: handle};

endmodule

>>> rtl/ast_ctrl.sv
// Scan unit and sequencer that examines the slot at the head of the ring and reports results.
`timescale 1ns / 1ps

module ast_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            mode,
  input  logic [15:0]           message_handle,
  input  logic [31:0]           alert_id,
  output logic                  busy,
  input  ast_pkg::slot_t        head,
  output ast_pkg::ring_t        ring,
  output logic                  done,
  output logic                  valid_entry,
  output logic [3:0]            slot_index,
  output logic [31:0]           result_id,
  output logic [15:0]           result_handle,
  output logic                  evicted,
  output logic                  found,
  output logic [31:0]           max_id,
  output logic                  last
);

  ast_pkg::state_t state, state_next;

  logic [ast_pkg::IDX_W-1:0] step;
  logic [1:0]                op_mode;
  logic [15:0]               op_handle;
  logic [31:0]               op_aid;

  logic                      free_found;
  logic [ast_pkg::IDX_W-1:0] free_idx;
  logic [31:0]               min_id;
  logic [ast_pkg::IDX_W-1:0] min_idx;
  logic [15:0]               min_handle;
  logic                      hit;
  logic [ast_pkg::IDX_W-1:0] hit_idx;
  logic [15:0]               hit_handle;
  logic [31:0]               scan_max;
  logic                      pend_valid;
  logic [ast_pkg::IDX_W-1:0] pend_idx;
  logic [31:0]               pend_id;
  logic [15:0]               pend_handle;
  logic [ast_pkg::CNT_W-1:0] taken;
  logic [31:0]               id_counter;
  logic [31:0]               max_reg;

  logic                      accept;
  logic                      head_free;
  logic                      cancel_hit;
  logic                      list_match;
  logic [31:0]               tail_id;
  logic [ast_pkg::IDX_W-1:0] pick;
  logic [31:0]               id_inc;
  logic [31:0]               new_id;
  logic [31:0]               keep_max;
  logic [31:0]               add_max;

  logic                      emit;
  logic                      e_valid;
  logic [ast_pkg::IDX_W-1:0] e_idx;
  logic [31:0]               e_id;
  logic [15:0]               e_handle;
  logic                      e_ev;
  logic                      e_found;
  logic [31:0]               e_max;
  logic                      e_last;

  assign busy = (state != ast_pkg::S_IDLE);
  assign accept = (state == ast_pkg::S_IDLE) && start;

  assign head_free = (head.id == 32'd0);
  assign cancel_hit = (op_mode == ast_pkg::MODE_CANCEL) && (op_aid != 32'd0) && !hit &&
                      (head.id == op_aid);
  assign list_match = (op_mode == ast_pkg::MODE_LIST) && (head.id > op_aid) &&
                      (taken < ast_pkg::CNT_W'(ast_pkg::MAX_RESULTS));
  assign tail_id = cancel_hit ? 32'd0 : head.id;

  assign pick = free_found ? free_idx : min_idx;
  assign id_inc = id_counter + 32'd1;
  assign new_id = (id_inc == 32'd0) ? 32'd1 : id_inc;

  // When a full single-slot table evicts, nothing else is left to hold the maximum.
  assign keep_max = (!free_found && ast_pkg::SLOT_COUNT == 1) ? 32'd0 : max_reg;
  assign add_max = (new_id > keep_max) ? new_id : keep_max;

  always_comb begin
    state_next = state;
    case (state)
      ast_pkg::S_IDLE: begin
        if (start) begin
          state_next = ast_pkg::S_SCAN;
        end
      end
      ast_pkg::S_SCAN: begin
        if (step == ast_pkg::LAST_STEP) begin
          state_next = ast_pkg::S_FINISH;
        end
      end
      ast_pkg::S_FINISH: begin
        state_next = ast_pkg::S_IDLE;
      end
      default: begin
        state_next = ast_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ring = '0;
    ring.tail = '{id: tail_id, handle: head.handle};
    emit = 1'b0;
    e_valid = 1'b0;
    e_idx = '0;
    e_id = '0;
    e_handle = '0;
    e_ev = 1'b0;
    e_found = 1'b0;
    e_max = max_reg;
    e_last = 1'b0;
    case (state)
      ast_pkg::S_SCAN: begin
        ring.shift = 1'b1;
        if (list_match && pend_valid) begin
          emit = 1'b1;
          e_valid = 1'b1;
          e_idx = pend_idx;
          e_id = pend_id;
          e_handle = pend_handle;
        end
      end
      ast_pkg::S_FINISH: begin
        emit = 1'b1;
        e_last = 1'b1;
        case (op_mode)
          ast_pkg::MODE_ADD: begin
            ring.write = 1'b1;
            ring.write_idx = pick;
            ring.write_data = '{id: new_id, handle: op_handle};
            e_valid = 1'b1;
            e_idx = pick;
            e_id = new_id;
            e_handle = free_found ? 16'd0 : min_handle;
            e_ev = !free_found;
            e_max = add_max;
          end
          ast_pkg::MODE_CANCEL: begin
            e_max = scan_max;
            if (hit) begin
              e_valid = 1'b1;
              e_idx = hit_idx;
              e_id = op_aid;
              e_handle = hit_handle;
              e_found = 1'b1;
            end
          end
          ast_pkg::MODE_LIST: begin
            if (pend_valid) begin
              e_valid = 1'b1;
              e_idx = pend_idx;
              e_id = pend_id;
              e_handle = pend_handle;
            end
          end
          default: begin
            e_valid = 1'b0;
          end
        endcase
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ast_pkg::S_IDLE;
      id_counter <= '0;
      max_reg <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= emit;
      if (state == ast_pkg::S_FINISH) begin
        if (op_mode == ast_pkg::MODE_ADD) begin
          id_counter <= new_id;
          max_reg <= add_max;
        end else if (op_mode == ast_pkg::MODE_CANCEL) begin
          max_reg <= scan_max;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step <= '0;
      op_mode <= mode;
      op_handle <= message_handle;
      op_aid <= alert_id;
      free_found <= 1'b0;
      hit <= 1'b0;
      scan_max <= '0;
      pend_valid <= 1'b0;
      taken <= '0;
    end else if (state == ast_pkg::S_SCAN) begin
      step <= step + ast_pkg::IDX_W'(1);
      if (head_free && !free_found) begin
        free_found <= 1'b1;
        free_idx <= step;
      end
      if (step == '0 || head.id < min_id) begin
        min_id <= head.id;
        min_idx <= step;
        min_handle <= head.handle;
      end
      if (cancel_hit) begin
        hit <= 1'b1;
        hit_idx <= step;
        hit_handle <= head.handle;
      end
      if (tail_id > scan_max) begin
        scan_max <= tail_id;
      end
      if (list_match) begin
        pend_valid <= 1'b1;
        pend_idx <= step;
        pend_id <= head.id;
        pend_handle <= head.handle;
        taken <= taken + ast_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      valid_entry <= e_valid;
      slot_index <= 4'(e_idx);
      result_id <= e_id;
      result_handle <= e_handle;
      evicted <= e_ev;
      found <= e_found;
      max_id <= e_max;
      last <= e_last;
    end
  end

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ast_pkg::S_SCAN || $past(state) == ast_pkg::S_FINISH))
    else $error("result strobe without an operation in progress");

  a_finish_reports_last: assert property (@(posedge clk) disable iff (rst)
    (state == ast_pkg::S_FINISH) |=> (done && last && state == ast_pkg::S_IDLE))
    else $error("finish cycle did not deliver the final result");

  a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ast_pkg::S_SCAN && step == '0))
    else $error("scan did not start at the first slot");

  a_early_not_last: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |-> ($past(state) == ast_pkg::S_SCAN && $past(op_mode) == ast_pkg::MODE_LIST))
    else $error("non-final result outside a list scan");

  a_counter_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ast_pkg::S_FINISH && op_mode == ast_pkg::MODE_ADD) |=> (id_counter != 32'd0))
    else $error("id counter handed out zero");

endmodule

>>> rtl/alert_slot_table_top.sv
// Top level of the alert slot table: the ring of slot cells and the scan unit.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low, and no further command is taken
// before the current one has passed its finish cycle (busy stays high till then): the slot ring
// rotates once past the scan unit at its head, one slot a cycle, and a finish cycle writes an
// added alert back and reports. Each result is shown for exactly one cycle with done high and
// cannot be held off by the receiver. A list transaction delivers its matches one by one while
// the ring rotates, the final one, marked by last, after the finish cycle; add, cancel and an
// unused mode give a single result. max_id always reflects the table after the command.
module alert_slot_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [15:0] message_handle,
  input  logic [31:0] alert_id,
  output logic        done,
  output logic        valid_entry,
  output logic [3:0]  slot_index,
  output logic [31:0] result_id,
  output logic [15:0] result_handle,
  output logic        evicted,
  output logic        found,
  output logic [31:0] max_id,
  output logic        last
);

  ast_pkg::slot_t cell_slot [ast_pkg::SLOT_COUNT];
  ast_pkg::ring_t ring;

  for (genvar i = 0; i < ast_pkg::SLOT_COUNT; i++) begin : g_cell
    ast_pkg::slot_t shift_in;
    logic           write;

    if (i == ast_pkg::SLOT_COUNT - 1) begin : g_tail
      assign shift_in = ring.tail;
    end else begin : g_link
      assign shift_in = cell_slot[i + 1];
    end

    assign write = ring.write && (ring.write_idx == ast_pkg::IDX_W'(i));

    ast_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (ring.shift),
      .shift_in   (shift_in),
      .write      (write),
      .write_data (ring.write_data),
      .slot       (cell_slot[i])
    );
  end

  ast_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .mode           (mode),
    .message_handle (message_handle),
    .alert_id       (alert_id),
    .busy           (busy),
    .head           (cell_slot[0]),
    .ring           (ring),
    .done           (done),
    .valid_entry    (valid_entry),
    .slot_index     (slot_index),
    .result_id      (result_id),
    .result_handle  (result_handle),
    .evicted        (evicted),
    .found          (found),
    .max_id         (max_id),
    .last           (last)
  );

endmodule
